[rtl/hcm_pkg.sv]
// ----------------------------------------------------------------------------
// Heartbeat consumer monitor package
// Shared types and constants for the heartbeat consumer monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package hcm_pkg;

    // Highest node id that may be monitored.
    localparam logic [7:0]  MAX_NODE_ID = 8'd127;

    // Base identifier of heartbeat frames.
    localparam logic [10:0] HB_BASE_ID  = 11'h700;

    // Input request codes.
    localparam logic [1:0]  OP_FRAME     = 2'd0;
    localparam logic [1:0]  OP_TICK      = 2'd1;
    localparam logic [1:0]  OP_SET_STATE = 2'd2;

    // Event codes of result items.
    localparam logic [1:0]  EV_OCCURRED = 2'd0;
    localparam logic [1:0]  EV_RESOLVED = 2'd1;
    localparam logic [1:0]  EV_CHANGED  = 2'd2;

    // Configuration register indexes.
    localparam int unsigned REG_INDEX_W = 2;
    localparam logic [REG_INDEX_W-1:0] REG_NODE_ID    = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_TIMEOUT_MS = 2'd1;

    // Width of the configuration write data (widest register).
    localparam int unsigned CFG_DATA_W = 16;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  first_byte;
        logic [7:0]  new_state;
    } item_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] node_number;
        logic [7:0] node_state;
    } result_t;

    // Classified work handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_HEARTBEAT = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_SET_STATE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] state;
    } cmd_t;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic [7:0]  node_id;
        logic [15:0] timeout_ms;
        logic        clear;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/hcm_fifo.sv]
// ----------------------------------------------------------------------------
// Heartbeat consumer monitor queue
// Small synchronous first-in first-out queue of DEPTH entries (DEPTH >= 2).
// ----------------------------------------------------------------------------
`default_nettype none

module hcm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[rtl/hcm_front.sv]
// ----------------------------------------------------------------------------
// Heartbeat consumer monitor front end
// Holds the configuration registers and sorts incoming requests into work.
// ----------------------------------------------------------------------------
`default_nettype none

module hcm_front (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   wr_en,
    input  wire logic [hcm_pkg::REG_INDEX_W-1:0]        wr_index,
    input  wire logic [hcm_pkg::CFG_DATA_W-1:0]         wr_data,
    input  wire logic                                   push,
    input  wire hcm_pkg::item_t                         item,
    input  wire logic                                   cmd_full,
    output logic                                        cmd_push,
    output hcm_pkg::cmd_t                               cmd,
    output hcm_pkg::cfg_t                               cfg
);

    logic [7:0]  node_id_reg, node_id_next;
    logic [15:0] timeout_ms_reg, timeout_ms_next;
    logic        enabled;
    logic        hb_match;
    logic        accepted;

    // Monitoring is live only for a legal node id and a nonzero timeout.
    assign enabled = (node_id_reg != 8'd0) && (node_id_reg <= hcm_pkg::MAX_NODE_ID)
                     && (timeout_ms_reg != 16'd0);

    assign hb_match = (item.frame_id == hcm_pkg::HB_BASE_ID + 11'(node_id_reg))
                      && (item.frame_len != 4'd0) && !item.first_byte[7];

    assign accepted = push && !cmd_full;

    always_comb
    begin
        node_id_next    = node_id_reg;
        timeout_ms_next = timeout_ms_reg;
        if (wr_en && wr_index == hcm_pkg::REG_NODE_ID)
        begin
            node_id_next = wr_data[7:0];
        end
        if (wr_en && wr_index == hcm_pkg::REG_TIMEOUT_MS)
        begin
            timeout_ms_next = wr_data;
        end
    end

    always_comb
    begin
        cmd_push  = 1'b0;
        cmd.kind  = hcm_pkg::CMD_TICK;
        cmd.state = item.first_byte;
        unique case (item.op)
            hcm_pkg::OP_FRAME:
            begin
                cmd.kind = hcm_pkg::CMD_HEARTBEAT;
                cmd_push = accepted && enabled && hb_match;
            end
            hcm_pkg::OP_TICK:
            begin
                cmd.kind = hcm_pkg::CMD_TICK;
                cmd_push = accepted;
            end
            hcm_pkg::OP_SET_STATE:
            begin
                cmd.kind  = hcm_pkg::CMD_SET_STATE;
                cmd.state = item.new_state;
                cmd_push  = accepted && enabled;
            end
            default:
            begin
                cmd_push = 1'b0;
            end
        endcase
    end

    assign cfg.node_id    = node_id_reg;
    assign cfg.timeout_ms = timeout_ms_reg;
    assign cfg.clear      = wr_en && (wr_index == hcm_pkg::REG_NODE_ID
                                      || wr_index == hcm_pkg::REG_TIMEOUT_MS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= '0;
            timeout_ms_reg <= '0;
        end
        else
        begin
            node_id_reg    <= node_id_next;
            timeout_ms_reg <= timeout_ms_next;
        end
    end

endmodule

`default_nettype wire

[rtl/hcm_back.sv]
// ----------------------------------------------------------------------------
// Heartbeat consumer monitor back end
// Carries out classified work on the node state and timeout, emits events.
// ----------------------------------------------------------------------------
`default_nettype none

module hcm_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hcm_pkg::cfg_t   cfg,
    input  wire hcm_pkg::cmd_t   cmd,
    input  wire logic            cmd_empty,
    output logic                 cmd_pop,
    input  wire logic            res_full,
    output logic                 res_push,
    output hcm_pkg::result_t     res
);

    logic [7:0]  last_state_reg, last_state_next;
    logic        error_flag_reg, error_flag_next;
    logic [15:0] time_left_reg, time_left_next;
    logic        timer_armed_reg, timer_armed_next;

    // Each command may produce a result, so only take one when there is room.
    assign cmd_pop = !cmd_empty && !res_full;

    always_comb
    begin
        last_state_next  = last_state_reg;
        error_flag_next  = error_flag_reg;
        time_left_next   = time_left_reg;
        timer_armed_next = timer_armed_reg;
        res_push         = 1'b0;
        res.event_kind   = hcm_pkg::EV_OCCURRED;
        res.node_number  = cfg.node_id;
        res.node_state   = 8'd0;

        if (cmd_pop)
        begin
            unique case (cmd.kind)
                hcm_pkg::CMD_HEARTBEAT:
                begin
                    last_state_next  = cmd.state;
                    time_left_next   = cfg.timeout_ms;
                    timer_armed_next = 1'b1;
                    if (error_flag_reg)
                    begin
                        error_flag_next = 1'b0;
                        res_push        = 1'b1;
                        res.event_kind  = hcm_pkg::EV_RESOLVED;
                    end
                    else if (last_state_reg != 8'd0 && cmd.state != last_state_reg)
                    begin
                        res_push       = 1'b1;
                        res.event_kind = hcm_pkg::EV_CHANGED;
                        res.node_state = cmd.state;
                    end
                end
                hcm_pkg::CMD_TICK:
                begin
                    if (timer_armed_reg)
                    begin
                        if (time_left_reg > 16'd1)
                        begin
                            time_left_next = time_left_reg - 16'd1;
                        end
                        else
                        begin
                            time_left_next   = 16'd0;
                            timer_armed_next = 1'b0;
                            error_flag_next  = 1'b1;
                            res_push         = 1'b1;
                            res.event_kind   = hcm_pkg::EV_OCCURRED;
                        end
                    end
                end
                hcm_pkg::CMD_SET_STATE:
                begin
                    last_state_next  = cmd.state;
                    time_left_next   = cfg.timeout_ms;
                    timer_armed_next = 1'b1;
                end
                default:
                begin
                    timer_armed_next = timer_armed_reg;
                end
            endcase
        end

        // A register write starts the monitor afresh.
        if (cfg.clear)
        begin
            last_state_next  = 8'd0;
            error_flag_next  = 1'b0;
            time_left_next   = 16'd0;
            timer_armed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_state_reg  <= '0;
            error_flag_reg  <= 1'b0;
            time_left_reg   <= '0;
            timer_armed_reg <= 1'b0;
        end
        else
        begin
            last_state_reg  <= last_state_next;
            error_flag_reg  <= error_flag_next;
            time_left_reg   <= time_left_next;
            timer_armed_reg <= timer_armed_next;
        end
    end

    // An armed timer always has time left to count.
    assert property (@(posedge clk) disable iff (!rst_n)
        timer_armed_reg |-> (time_left_reg != 16'd0))
        else $error("armed timer with no time left");

    // An expiry event leaves the timer disarmed and the error raised.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.event_kind == hcm_pkg::EV_OCCURRED && !cfg.clear)
        |=> (!timer_armed_reg && error_flag_reg))
        else $error("expiry event without error state");

    // A resolved event clears the error and re-arms the timer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.event_kind == hcm_pkg::EV_RESOLVED && !cfg.clear)
        |=> (!error_flag_reg && timer_armed_reg))
        else $error("resolved event left error pending");

    // No event is produced without taking a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> cmd_pop)
        else $error("event produced without a command");

endmodule

`default_nettype wire

[rtl/heartbeat_consumer_monitor_unit.sv]
// ----------------------------------------------------------------------------
// Heartbeat consumer monitor
// Watches the heartbeats of one remote node and reports timeout events.
// ----------------------------------------------------------------------------
// Requests arrive on a queue-like port: a request is taken on a rising edge
// with push high and full low. Each request is a received frame, a millisecond
// tick or a local set of the node state. Events leave through a second
// queue-like port: the oldest event sits on result while empty is low and is
// removed on an edge with pop high.
// The front end checks each request against the configuration and drops those
// that cannot matter; the rest go through a short command queue to the back
// end, which updates the node state and the one-shot timeout and writes any
// event into the result queue. One request is taken every cycle while full is
// low; the command behind an event passes through the command queue, and the
// event then through the result queue, before it can be popped.
// After reset both registers are zero, so monitoring is off, and the state is
// cleared. When the receiver stops popping, the result queue fills, the back
// end waits, then the command queue fills and full rises; nothing is lost.
// Configuration writes take effect at once and clear the monitor state. The
// user must make them only while no request is in flight; nothing enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_consumer_monitor_unit #(
    parameter int unsigned CMD_QUEUE_DEPTH    = 2,
    parameter int unsigned RESULT_QUEUE_DEPTH = 2
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [hcm_pkg::REG_INDEX_W-1:0]    wr_index,
    input  wire logic [hcm_pkg::CFG_DATA_W-1:0]     wr_data,
    input  wire logic                               push,
    input  wire hcm_pkg::item_t                     item,
    output logic                                    full,
    input  wire logic                               pop,
    output hcm_pkg::result_t                        result,
    output logic                                    empty
);

    localparam int unsigned CMD_W = $bits(hcm_pkg::cmd_t);
    localparam int unsigned RES_W = $bits(hcm_pkg::result_t);

    hcm_pkg::cfg_t    cfg;
    hcm_pkg::cmd_t    cmd_in;
    hcm_pkg::cmd_t    cmd_out;
    hcm_pkg::result_t res_in;
    logic [CMD_W-1:0] cmd_out_bits;
    logic [RES_W-1:0] result_bits;
    logic             cmd_push;
    logic             cmd_pop;
    logic             cmd_full;
    logic             cmd_empty;
    logic             res_push;
    logic             res_full;

    // Full tracks the command queue: a request the front end drops still
    // needs the port to be free, which keeps acceptance simple.
    assign full = cmd_full;

    hcm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .item     (item),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cfg      (cfg)
    );

    hcm_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (CMD_W'(cmd_in)),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out_bits),
        .empty (cmd_empty)
    );

    assign cmd_out = hcm_pkg::cmd_t'(cmd_out_bits);

    hcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    hcm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (RES_W'(res_in)),
        .full  (res_full),
        .pop   (pop),
        .rdata (result_bits),
        .empty (empty)
    );

    assign result = hcm_pkg::result_t'(result_bits);

endmodule

`default_nettype wire

[verif/heartbeat_consumer_monitor_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heartbeat consumer monitor testbench
// Runs a short table of directed requests and then phases of random requests
// under several register settings. Events are checked field by field against
// a cycle-free model of the monitor kept inside this bench.
// ----------------------------------------------------------------------------

module heartbeat_consumer_monitor_unit_test;

    // The request code that the block does not use and must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int unsigned RESET_CYCLES    = 10;
    // An event passes through the command queue and the result queue; a request
    // that gives no event may still sit in the command queue, so wait a settle pause.
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 60;
    // Longest honest quiet spell is the receiver hold-off plus a settle pause
    // and a sender gap; this is many times that.
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned PHASE_COUNT     = 11;

    // How a row of the directed table is treated.
    typedef enum logic [1:0] {
        ROW_CONFIG    = 2'd0,
        ROW_PREDICTED = 2'd1,
        ROW_QUIET     = 2'd2,
        ROW_EVENT     = 2'd3
    } row_kind_t;

    typedef struct packed {
        row_kind_t                         kind;
        hcm_pkg::item_t                    req;
        hcm_pkg::result_t                  want;
        logic [hcm_pkg::REG_INDEX_W-1:0]   reg_index;
        logic [hcm_pkg::CFG_DATA_W-1:0]    reg_value;
    } row_t;

    // Patterns on which the receiver takes events.
    typedef enum logic [1:0] {
        POP_STEADY   = 2'd0,
        POP_RANDOM   = 2'd1,
        POP_PERIODIC = 2'd2
    } pop_mode_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             wr_en;
    logic [hcm_pkg::REG_INDEX_W-1:0]  wr_index;
    logic [hcm_pkg::CFG_DATA_W-1:0]   wr_data;
    logic                             push;
    hcm_pkg::item_t                   item;
    logic                             full;
    logic                             pop;
    hcm_pkg::result_t                 result;
    logic                             empty;

    // Our own copy of the monitor: registers and state.
    logic [7:0]  mon_node_id;
    logic [15:0] mon_timeout;
    logic [7:0]  known_state;
    logic        error_pending;
    logic [15:0] ms_left;
    logic        timer_running;

    hcm_pkg::result_t pending_events[$];
    row_t             plan[$];

    int unsigned error_count     = 0;
    int unsigned requests_taken  = 0;
    int unsigned settings_used   = 0;
    int unsigned occurred_seen   = 0;
    int unsigned resolved_seen   = 0;
    int unsigned changed_seen    = 0;
    int unsigned burst_left      = 0;
    int unsigned stalled_cycles  = 0;
    bit          hold_off_wanted = 1'b0;

    heartbeat_consumer_monitor_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .item     (item),
        .full     (full),
        .pop      (pop),
        .result   (result),
        .empty    (empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model of the monitor
    // ------------------------------------------------------------------------

    // Monitoring runs only for a node id in the legal range and a nonzero
    // consumer time.
    function automatic bit monitoring_on();
        return mon_node_id != 8'd0 && mon_node_id <= hcm_pkg::MAX_NODE_ID
               && mon_timeout != 16'd0;
    endfunction

    // A write to either register clears the node state, the error and the
    // timer; any other index is ignored.
    function automatic void set_register(input logic [hcm_pkg::REG_INDEX_W-1:0] index,
                                         input logic [hcm_pkg::CFG_DATA_W-1:0] value);
        if (index == hcm_pkg::REG_NODE_ID)
            mon_node_id = value[7:0];
        else if (index == hcm_pkg::REG_TIMEOUT_MS)
            mon_timeout = value;
        else
            return;
        known_state   = 8'd0;
        error_pending = 1'b0;
        ms_left       = 16'd0;
        timer_running = 1'b0;
    endfunction

    // Applies one accepted request to the model; returns 1 with the event
    // when the request gives one.
    function automatic bit predict_heartbeat(input hcm_pkg::item_t req,
                                             output hcm_pkg::result_t ev);
        logic [7:0] old_state;
        bit         fired;
        fired = 1'b0;
        ev = '0;
        ev.node_number = mon_node_id;
        case (req.op)
            hcm_pkg::OP_FRAME:
            begin
                // Only a frame from the monitored node with data and a clear
                // toggle bit counts as a heartbeat.
                if (monitoring_on()
                    && req.frame_id == hcm_pkg::HB_BASE_ID + 11'(mon_node_id)
                    && req.frame_len != 4'd0 && !req.first_byte[7])
                begin
                    old_state     = known_state;
                    known_state   = req.first_byte;
                    ms_left       = mon_timeout;
                    timer_running = 1'b1;
                    if (error_pending)
                    begin
                        error_pending = 1'b0;
                        ev.event_kind = hcm_pkg::EV_RESOLVED;
                        fired = 1'b1;
                    end
                    else if (old_state != 8'd0 && req.first_byte != old_state)
                    begin
                        ev.event_kind = hcm_pkg::EV_CHANGED;
                        ev.node_state = req.first_byte;
                        fired = 1'b1;
                    end
                end
            end
            hcm_pkg::OP_TICK:
            begin
                if (timer_running)
                begin
                    if (ms_left > 16'd1)
                        ms_left = ms_left - 16'd1;
                    else
                    begin
                        // The timeout is one-shot: it reports and disarms,
                        // even when an error is already pending.
                        ms_left       = 16'd0;
                        timer_running = 1'b0;
                        error_pending = 1'b1;
                        ev.event_kind = hcm_pkg::EV_OCCURRED;
                        fired = 1'b1;
                    end
                end
            end
            hcm_pkg::OP_SET_STATE:
            begin
                if (monitoring_on())
                begin
                    known_state   = req.new_state;
                    ms_left       = mon_timeout;
                    timer_running = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return fired;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------

    function automatic void add_setting(input logic [hcm_pkg::REG_INDEX_W-1:0] index,
                                        input logic [hcm_pkg::CFG_DATA_W-1:0] value);
        row_t r;
        r = '0;
        r.kind      = ROW_CONFIG;
        r.reg_index = index;
        r.reg_value = value;
        plan.push_back(r);
    endfunction

    function automatic void add_request(input row_kind_t kind, input logic [1:0] op,
                                        input logic [10:0] fid, input logic [3:0] len,
                                        input logic [7:0] b0, input logic [7:0] nst,
                                        input logic [1:0] ev_kind, input logic [7:0] ev_node,
                                        input logic [7:0] ev_state);
        row_t r;
        r = '0;
        r.kind                 = kind;
        r.req.op               = op;
        r.req.frame_id         = fid;
        r.req.frame_len        = len;
        r.req.first_byte       = b0;
        r.req.new_state        = nst;
        r.want.event_kind      = ev_kind;
        r.want.node_number     = ev_node;
        r.want.node_state      = ev_state;
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one request, waits for it to be taken and records what it should
    // give. Requests go out in bursts with idle gaps between them.
    task automatic offer_request(input hcm_pkg::item_t req, input row_kind_t how,
                                 input hcm_pkg::result_t want);
        hcm_pkg::result_t ev;
        bit               fired;
        int unsigned      gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(8, 1);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
            end
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 30)
                                                     : $urandom_range(12, 1);
        end
        burst_left--;
        @(negedge clk);
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        requests_taken++;
        fired = predict_heartbeat(req, ev);
        case (how)
            ROW_PREDICTED:
            begin
                if (fired)
                    pending_events.push_back(ev);
            end
            ROW_EVENT:
                pending_events.push_back(want);
            default:
            begin
            end
        endcase
    endtask

    // Stops offering and waits until every expected event has been taken and
    // any request that gives none has left the pipeline.
    task automatic wait_until_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [hcm_pkg::REG_INDEX_W-1:0] index,
                                  input logic [hcm_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        set_register(index, value);
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    // Random request, mostly heartbeats from the monitored node and ticks so
    // that the timer really expires and recovers; the rest is broken frames,
    // foreign traffic, local state sets and the unused code.
    function automatic hcm_pkg::item_t draw_request();
        hcm_pkg::item_t req;
        int unsigned    pick;
        int unsigned    flaw;
        req.op         = hcm_pkg::OP_FRAME;
        req.frame_id   = 11'($urandom);
        req.frame_len  = 4'($urandom_range(15, 0));
        req.first_byte = 8'($urandom);
        req.new_state  = 8'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 38)
            req.op = hcm_pkg::OP_TICK;
        else if (pick < 70 || pick < 80)
        begin
            req.frame_id  = hcm_pkg::HB_BASE_ID + 11'(mon_node_id);
            req.frame_len = ($urandom_range(7, 0) == 0) ? 4'($urandom_range(15, 9))
                                                        : 4'($urandom_range(8, 1));
            // Small states repeat often, which exercises both the unchanged
            // and the changed path.
            req.first_byte = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(127, 0))
                                                         : 8'($urandom_range(3, 0));
            if (pick >= 70)
            begin
                // A heartbeat spoilt in one way only.
                flaw = $urandom_range(2, 0);
                if (flaw == 0)
                    req.frame_len = 4'd0;
                else if (flaw == 1)
                    req.first_byte[7] = 1'b1;
                else
                    req.frame_id = req.frame_id ^ (11'd1 << $urandom_range(10, 0));
            end
        end
        else if (pick < 90)
            req.op = hcm_pkg::OP_SET_STATE;
        else if (pick < 95)
            req.op = OP_UNUSED;
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------

    // The receiver changes its pattern every so often, and on request holds
    // off altogether for a long stretch so that both queues fill up.
    initial
    begin : result_taker
        pop_mode_t   mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned beat;
        mode      = POP_STEADY;
        mode_left = 0;
        hold_left = 0;
        beat      = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_wanted)
            begin
                hold_off_wanted = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = pop_mode_t'($urandom_range(2, 0));
                mode_left = $urandom_range(100, 30);
            end
            mode_left--;
            beat++;
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (mode)
                    POP_STEADY:   pop <= 1'b1;
                    POP_RANDOM:   pop <= 1'($urandom_range(1, 0));
                    default:      pop <= (beat % 5) >= 2;
                endcase
            end
        end
    end

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // Each event taken is compared with the oldest one still expected.
    always @(posedge clk)
    begin : event_check
        hcm_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_events.size() == 0)
            begin
                error_count++;
                $display("%0t ns: expected no event, got kind %0d node %0d state %0d",
                         $time, result.event_kind, result.node_number,
                         result.node_state);
            end
            else
            begin
                want = pending_events.pop_front();
                compare_field("event_kind", 8'(want.event_kind), 8'(result.event_kind));
                compare_field("node_number", want.node_number, result.node_number);
                compare_field("node_state", want.node_state, result.node_state);
                case (want.event_kind)
                    hcm_pkg::EV_OCCURRED: occurred_seen++;
                    hcm_pkg::EV_RESOLVED: resolved_seen++;
                    default:              changed_seen++;
                endcase
            end
        end
    end

    // Ends the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stalled_cycles = 0;
        else
        begin
            stalled_cycles++;
            if (stalled_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no request or event moved for %0d cycles",
                         $time, WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        int unsigned      phase;
        int unsigned      n;
        int unsigned      count;
        logic [7:0]       node;
        logic [15:0]      tmo;
        hcm_pkg::result_t none;
        none = '0;
        rst_n    <= 1'b0;
        push     <= 1'b0;
        item     <= '0;
        wr_en    <= 1'b0;
        wr_index <= hcm_pkg::REG_NODE_ID;
        wr_data  <= '0;
        mon_node_id = 8'd0;
        mon_timeout = 16'd0;
        set_register(hcm_pkg::REG_NODE_ID, '0);
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;

        // Straight after reset both registers are zero, so nothing counts.
        add_request(ROW_QUIET, hcm_pkg::OP_FRAME, 11'h700, 4'd1, 8'h01, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_QUIET, hcm_pkg::OP_TICK, 11'h000, 4'd0, 8'h00, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_QUIET, hcm_pkg::OP_SET_STATE, 11'h000, 4'd0, 8'h00, 8'h33,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        // Node 5 with a 3 ms consumer time.
        add_setting(hcm_pkg::REG_NODE_ID, 16'd5);
        add_setting(hcm_pkg::REG_TIMEOUT_MS, 16'd3);
        // A tick before any heartbeat finds the timer idle.
        add_request(ROW_QUIET, hcm_pkg::OP_TICK, 11'h000, 4'd0, 8'h00, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        // Empty frame, toggle bit set and a neighbour's id are all dropped.
        add_request(ROW_QUIET, hcm_pkg::OP_FRAME, 11'h705, 4'd0, 8'h05, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_QUIET, hcm_pkg::OP_FRAME, 11'h705, 4'd1, 8'h85, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_QUIET, hcm_pkg::OP_FRAME, 11'h704, 4'd1, 8'h05, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        // First heartbeat, longest length; then a change and a repeat.
        add_request(ROW_PREDICTED, hcm_pkg::OP_FRAME, 11'h705, 4'd15, 8'h05, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_EVENT, hcm_pkg::OP_FRAME, 11'h705, 4'd8, 8'h7F, 8'h00,
                    hcm_pkg::EV_CHANGED, 8'd5, 8'h7F);
        add_request(ROW_PREDICTED, hcm_pkg::OP_FRAME, 11'h705, 4'd1, 8'h7F, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        // Three ticks run the timer out; a fourth finds it disarmed.
        add_request(ROW_PREDICTED, hcm_pkg::OP_TICK, 11'h000, 4'd0, 8'h00, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_PREDICTED, hcm_pkg::OP_TICK, 11'h000, 4'd0, 8'h00, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_EVENT, hcm_pkg::OP_TICK, 11'h000, 4'd0, 8'h00, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd5, 8'd0);
        add_request(ROW_QUIET, hcm_pkg::OP_TICK, 11'h000, 4'd0, 8'h00, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        // The next heartbeat resolves the error rather than reporting a change.
        add_request(ROW_EVENT, hcm_pkg::OP_FRAME, 11'h705, 4'd1, 8'h00, 8'h00,
                    hcm_pkg::EV_RESOLVED, 8'd5, 8'd0);
        add_request(ROW_PREDICTED, hcm_pkg::OP_FRAME, 11'h705, 4'd2, 8'h04, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        // A local set of the state is compared against by the next heartbeat.
        add_request(ROW_PREDICTED, hcm_pkg::OP_SET_STATE, 11'h000, 4'd0, 8'h00, 8'hFF,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_EVENT, hcm_pkg::OP_FRAME, 11'h705, 4'd1, 8'h04, 8'h00,
                    hcm_pkg::EV_CHANGED, 8'd5, 8'h04);
        add_request(ROW_QUIET, OP_UNUSED, 11'h7FF, 4'd15, 8'hFF, 8'hFF,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        // Highest node id with the longest consumer time.
        add_setting(hcm_pkg::REG_NODE_ID, 16'd127);
        add_setting(hcm_pkg::REG_TIMEOUT_MS, 16'hFFFF);
        add_request(ROW_PREDICTED, hcm_pkg::OP_FRAME, 11'h77F, 4'd1, 8'h7F, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_EVENT, hcm_pkg::OP_FRAME, 11'h77F, 4'd1, 8'h01, 8'h00,
                    hcm_pkg::EV_CHANGED, 8'd127, 8'h01);
        add_request(ROW_QUIET, hcm_pkg::OP_SET_STATE, 11'h000, 4'd0, 8'h00, 8'h80,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_EVENT, hcm_pkg::OP_FRAME, 11'h77F, 4'd1, 8'h02, 8'h00,
                    hcm_pkg::EV_CHANGED, 8'd127, 8'h02);
        // Shortest consumer time: the first tick after a heartbeat expires.
        add_setting(hcm_pkg::REG_TIMEOUT_MS, 16'd1);
        add_request(ROW_PREDICTED, hcm_pkg::OP_FRAME, 11'h77F, 4'd1, 8'h10, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd0, 8'd0);
        add_request(ROW_EVENT, hcm_pkg::OP_TICK, 11'h000, 4'd0, 8'h00, 8'h00,
                    hcm_pkg::EV_OCCURRED, 8'd127, 8'd0);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CONFIG)
            begin
                wait_until_idle();
                write_register(plan[i].reg_index, plan[i].reg_value);
                settings_used++;
            end
            else
                offer_request(plan[i].req, plan[i].kind, plan[i].want);
        end

        // Random phases. Settings that switch monitoring off get short phases,
        // since no request in them has any effect.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       begin node = 8'd1;   tmo = 16'd1;     count = 90; end
                1:       begin node = 8'd127; tmo = 16'd2;     count = 90; end
                2:       begin node = 8'd128; tmo = 16'd4;     count = 15; end
                3:       begin node = 8'd255; tmo = 16'd6;     count = 15; end
                4:       begin node = 8'd42;  tmo = 16'd0;     count = 15; end
                5:       begin node = 8'd0;   tmo = 16'hFFFF;  count = 15; end
                6:       begin node = 8'd127; tmo = 16'hFFFF;  count = 60; end
                default:
                begin
                    node  = 8'($urandom_range(127, 1));
                    tmo   = 16'($urandom_range(12, 1));
                    count = 85;
                end
            endcase
            wait_until_idle();
            if ($urandom_range(1, 0) == 0)
            begin
                write_register(hcm_pkg::REG_NODE_ID, 16'(node));
                write_register(hcm_pkg::REG_TIMEOUT_MS, tmo);
            end
            else
            begin
                write_register(hcm_pkg::REG_TIMEOUT_MS, tmo);
                write_register(hcm_pkg::REG_NODE_ID, 16'(node));
            end
            settings_used++;
            // With a 1 ms timeout nearly every tick gives an event, so a long
            // hold-off here backs up the result queue and then the input.
            if (phase == 0 || phase == 8)
                hold_off_wanted = 1'b1;
            for (n = 0; n < count; n++)
                offer_request(draw_request(), ROW_PREDICTED, none);
        end

        wait_until_idle();
        $display("Covered %0d requests over %0d register settings, directed and random.",
                 requests_taken, settings_used);
        $display("Events checked: %0d occurred, %0d resolved, %0d changed; %0d mismatches.",
                 occurred_seen, resolved_seen, changed_seen, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
